// File: hdl/sqc_pkg.sv
package sqc_pkg;

  localparam int STEPS_DEFAULT     = 16;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int LEN_W  = 34;
  localparam int REF_W  = 18;
  localparam int STEP_W = 8;
  localparam int CNT_W  = 19;
  localparam int CFG_W  = 34;

  localparam logic [REF_W-1:0] CD_MAX = '1;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_STEP = 2'd1,
    CMD_START    = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_NEW_STEP = 2'd2,
    EV_UNUSED   = 2'd3
  } event_t;

  typedef enum logic {
    REG_STEP_LENGTH = 1'b0,
    REG_NOTE_REF    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t              command;
    logic [STEP_W-1:0] step_index;
    logic [REF_W-1:0]  samples_left;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// File: hdl/sqc_in_stage.sv
module sqc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sqc_pkg::item_t  in_item,
  input  logic            take,
  output sqc_pkg::stage_t stage
);

  logic           valid;
  sqc_pkg::item_t item;

  // The slot refills in the same cycle the core consumes it.
  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// File: hdl/sqc_core.sv
module sqc_core #(
  parameter int STEPS     = sqc_pkg::STEPS_DEFAULT,
  parameter int FRAC_BITS = sqc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sqc_pkg::stage_t              stage,
  output logic                         take,
  input  logic [sqc_pkg::LEN_W-1:0]    step_length_q16,
  input  logic [sqc_pkg::REF_W-1:0]    note_length_ref,
  output logic                         res_valid,
  input  logic                         res_ready,
  output sqc_pkg::event_t              event_res,
  output logic [sqc_pkg::STEP_W-1:0]   current_step
);

  localparam int LW  = sqc_pkg::LEN_W;
  localparam int SW  = sqc_pkg::STEP_W;
  localparam int CW  = sqc_pkg::CNT_W;
  localparam int RFW = sqc_pkg::REF_W;
  localparam int F   = FRAC_BITS;
  localparam int DW  = F + 2;
  localparam int RW  = LW + 1 - F;
  localparam int XW  = (RW + 2 > CW + 1) ? RW + 2 : CW + 1;

  localparam logic [LW:0]         HALF_L = (LW + 1)'(1) << (F - 1);
  localparam logic signed [DW-1:0] HALF  = DW'(1) << (F - 1);
  localparam logic signed [DW-1:0] ONE   = DW'(1) << F;
  localparam logic [SW:0]          LAST  = (SW + 1)'(STEPS - 1);

  logic signed [CW-1:0] countdown;
  logic signed [DW-1:0] drift_q16;
  logic [SW-1:0]        playing_step;
  logic [SW-1:0]        upcoming_step;
  logic                 running;

  logic signed [CW-1:0] countdown_next;
  logic signed [DW-1:0] drift_next;
  logic [SW-1:0]        playing_next;
  logic [SW-1:0]        upcoming_next;
  logic                 running_next;
  sqc_pkg::event_t      event_next;

  logic [SW-1:0]        wrap_tab [256];

  logic [LW:0]          rounded;
  logic [RW-1:0]        r_len;
  logic [F-1:0]         rem;
  logic signed [DW-1:0] delta;
  logic signed [DW-1:0] drift_sum;
  logic                 drift_low;
  logic                 drift_high;
  logic signed [XW-1:0] cd_wide;
  logic signed [CW-1:0] cd_dec;
  logic [RFW+3:0]       cd_times10;
  logic [SW-1:0]        step_after;

  for (genvar i = 0; i < 256; i++) begin : g_wrap
    localparam int WRAPPED = i % STEPS;
    assign wrap_tab[i] = SW'(WRAPPED);
  end

  assign take = stage.valid && (!res_valid || res_ready);

  always_comb begin
    rounded    = {1'b0, step_length_q16} + HALF_L;
    r_len      = rounded[LW:F];
    rem        = rounded[F-1:0];
    // Rounding error of this reload, in (-half, half].
    delta      = HALF - $signed({2'b00, rem});
    drift_sum  = drift_q16 + delta;
    drift_low  = drift_sum < -HALF;
    drift_high = drift_sum >= HALF;
    cd_dec     = countdown - CW'(1);
    cd_times10 = (RFW + 4)'(cd_dec[RFW-1:0]) * (RFW + 4)'(10);
    // The queued step starts playing, so the queue moves on from it.
    step_after = ({1'b0, upcoming_step} == LAST) ? '0
               : SW'({1'b0, upcoming_step} + (SW + 1)'(1));

    cd_wide = $signed({{(XW - RW){1'b0}}, r_len});
    if (drift_low) begin
      cd_wide = cd_wide + XW'(1);
    end else if (drift_high) begin
      cd_wide = cd_wide - XW'(1);
    end
  end

  always_comb begin
    countdown_next = countdown;
    drift_next     = drift_q16;
    playing_next   = playing_step;
    upcoming_next  = upcoming_step;
    running_next   = running;
    event_next     = sqc_pkg::EV_NONE;
    unique case (stage.item.command)
      sqc_pkg::CMD_TICK: begin
        if (running) begin
          if (countdown > 0) begin
            countdown_next = cd_dec;
            if (note_length_ref != '0 &&
                cd_times10 < (RFW + 4)'(note_length_ref)) begin
              event_next = sqc_pkg::EV_NOTE_OFF;
            end
          end else begin
            if (drift_low) begin
              drift_next = drift_sum + ONE;
            end else if (drift_high) begin
              drift_next = drift_sum - ONE;
            end else begin
              drift_next = drift_sum;
            end
            if (cd_wide > $signed(XW'(sqc_pkg::CD_MAX))) begin
              countdown_next = CW'(sqc_pkg::CD_MAX);
            end else begin
              countdown_next = CW'(cd_wide);
            end
            playing_next  = upcoming_step;
            upcoming_next = step_after;
            event_next    = sqc_pkg::EV_NEW_STEP;
          end
        end
      end
      sqc_pkg::CMD_SET_STEP: begin
        upcoming_next  = wrap_tab[stage.item.step_index];
        countdown_next = CW'(stage.item.samples_left);
      end
      sqc_pkg::CMD_START: begin
        running_next = 1'b1;
      end
      sqc_pkg::CMD_STOP: begin
        running_next = 1'b0;
      end
      default: begin
        running_next = running;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown     <= '1;
      drift_q16     <= '0;
      playing_step  <= '0;
      upcoming_step <= '0;
      running       <= 1'b1;
      res_valid     <= 1'b0;
    end else begin
      if (take) begin
        countdown     <= countdown_next;
        drift_q16     <= drift_next;
        playing_step  <= playing_next;
        upcoming_step <= upcoming_next;
        running       <= running_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      event_res    <= event_next;
      current_step <= playing_next;
    end
  end

endmodule

// File: hdl/step_sequencer_clock.sv
// Step clock for a sequencer, driven by one transaction per audio sample.
// Slave channel: s_tuser carries the command (tick, set step, start, stop),
// s_tdata carries the step index and the countdown for a set step.
// Master channel: one result transaction for every input transaction, with
// the event (none, note off, new step) in m_tuser and the playing step in
// m_tdata. A new step reloads the countdown from step_length_q16, rounded
// half up and corrected by a drift accumulator.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 = step length in fixed point, 1 = note-off reference length); write
// only while no transaction is in flight.
// An accepted input passes through the input register and then the update
// logic that feeds the result register. Throughput is one transaction per
// cycle while m_tready stays high; the state is updated as each
// transaction is taken.
// A synchronous reset empties both registers and returns the clock to step
// zero, running, with the countdown at minus one. When the receiver stalls,
// the result holds and s_tready drops once the input register is full.
module step_sequencer_clock #(
  parameter int STEPS     = sqc_pkg::STEPS_DEFAULT,
  parameter int FRAC_BITS = sqc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // step_index, samples_left, zeros
  input  logic [1:0]                s_tuser,   // command
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // current_step
  output logic [1:0]                m_tuser,   // event_res
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sqc_pkg::CFG_W-1:0] cfg_wdata
);

  logic [sqc_pkg::LEN_W-1:0]  step_length_q16;
  logic [sqc_pkg::REF_W-1:0]  note_length_ref;
  sqc_pkg::item_t             in_item;
  sqc_pkg::stage_t            stage;
  sqc_pkg::event_t            event_res;
  logic                       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length_q16 <= sqc_pkg::LEN_W'(1) << FRAC_BITS;
      note_length_ref <= '0;
    end else if (cfg_we) begin
      unique case (sqc_pkg::cfg_reg_t'(cfg_index))
        sqc_pkg::REG_STEP_LENGTH: begin
          step_length_q16 <= cfg_wdata[sqc_pkg::LEN_W-1:0];
        end
        sqc_pkg::REG_NOTE_REF: begin
          note_length_ref <= cfg_wdata[sqc_pkg::REF_W-1:0];
        end
        default: begin
          note_length_ref <= note_length_ref;
        end
      endcase
    end
  end

  assign in_item.command      = sqc_pkg::cmd_t'(s_tuser);
  assign in_item.step_index   = s_tdata[7:0];
  assign in_item.samples_left = s_tdata[25:8];

  sqc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .take     (take),
    .stage    (stage)
  );

  sqc_core #(
    .STEPS     (STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .stage           (stage),
    .take            (take),
    .step_length_q16 (step_length_q16),
    .note_length_ref (note_length_ref),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .event_res       (event_res),
    .current_step    (m_tdata)
  );

  assign m_tuser = event_res;

endmodule

// File: dv/step_sequencer_clock_checker.sv
`timescale 1ns / 100ps

module step_sequencer_clock_checker #(
  parameter int STEPS     = sqc_pkg::STEPS_DEFAULT,
  parameter int FRAC_BITS = sqc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [31:0]               s_tdata,   // step_index, samples_left, zeros
  input  logic [1:0]                s_tuser,   // command
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [7:0]                m_tdata,   // current_step
  input  logic [1:0]                m_tuser,   // event_res
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sqc_pkg::CFG_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        pending
);

  localparam int     LEN_W   = sqc_pkg::LEN_W;
  localparam int     REF_W   = sqc_pkg::REF_W;
  localparam int     STEP_W  = sqc_pkg::STEP_W;
  localparam int     CNT_W   = sqc_pkg::CNT_W;
  localparam int     DRIFT_W = FRAC_BITS + 2;
  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q  = longint'(1) << (FRAC_BITS - 1);
  localparam longint CD_CEIL = longint'(sqc_pkg::CD_MAX);

  typedef struct {
    sqc_pkg::event_t   ev;
    logic [STEP_W-1:0] step;
  } step_report_t;

  step_report_t reports_due[$];
  int           mismatch_cnt;

  logic        [LEN_W-1:0]   step_len;
  logic        [REF_W-1:0]   note_ref;
  logic signed [CNT_W-1:0]   countdown;
  logic signed [DRIFT_W-1:0] drift;
  logic        [STEP_W-1:0]  playing;
  logic        [STEP_W-1:0]  upcoming;
  logic                      running;

  initial begin
    errors       = 0;
    pending      = 0;
    mismatch_cnt = 0;
  end

  // Applies one accepted command to the predicted clock state.
  task automatic advance_clock(input sqc_pkg::cmd_t cmd, input logic [STEP_W-1:0] idx,
                               input logic [REF_W-1:0] left,
                               output sqc_pkg::event_t ev);
    longint reload;
    longint drift_next;
    ev = sqc_pkg::EV_NONE;
    case (cmd)
      sqc_pkg::CMD_TICK: begin
        if (running) begin
          if (countdown > 0) begin
            countdown = countdown - 1;
            if (note_ref != 0 && longint'(countdown) * 10 < longint'(note_ref))
              ev = sqc_pkg::EV_NOTE_OFF;
          end else begin
            reload     = (longint'(step_len) + HALF_Q) >> FRAC_BITS;
            drift_next = longint'(drift) + (reload << FRAC_BITS) - longint'(step_len);
            if (drift_next < -HALF_Q) begin
              drift_next = drift_next + ONE_Q;
              reload     = reload + 1;
            end else if (drift_next >= HALF_Q) begin
              drift_next = drift_next - ONE_Q;
              reload     = reload - 1;
            end
            // Saturation leaves the drift as it is.
            if (reload > CD_CEIL)
              reload = CD_CEIL;
            countdown = reload[CNT_W-1:0];
            drift     = drift_next[DRIFT_W-1:0];
            playing   = upcoming;
            upcoming  = STEP_W'((int'(playing) + 1) % STEPS);
            ev        = sqc_pkg::EV_NEW_STEP;
          end
        end
      end
      sqc_pkg::CMD_SET_STEP: begin
        upcoming  = STEP_W'(int'(idx) % STEPS);
        countdown = {1'b0, left};
      end
      sqc_pkg::CMD_START: running = 1'b1;
      default:            running = 1'b0;
    endcase
  endtask

  always @(posedge clk) begin
    step_report_t    want;
    sqc_pkg::event_t ev;
    if (rst) begin
      step_len  = LEN_W'(ONE_Q);
      note_ref  = '0;
      countdown = '1;
      drift     = '0;
      playing   = '0;
      upcoming  = '0;
      running   = 1'b1;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (sqc_pkg::cfg_reg_t'(cfg_index))
          sqc_pkg::REG_STEP_LENGTH: step_len = cfg_wdata[LEN_W-1:0];
          default:                  note_ref = cfg_wdata[REF_W-1:0];
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (reports_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result transaction: event %0d step %0d",
                     $time, m_tuser, m_tdata);
        end else begin
          want = reports_due.pop_front();
          if (m_tuser !== want.ev || m_tdata !== want.step) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result mismatch: event exp %0d got %0d, step exp %0d got %0d",
                       $time, want.ev, m_tuser, want.step, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_clock(sqc_pkg::cmd_t'(s_tuser), s_tdata[7:0], s_tdata[25:8], ev);
        want.ev   = ev;
        want.step = playing;
        reports_due.push_back(want);
      end
    end
    pending <= reports_due.size();
    errors  <= mismatch_cnt;
  end

endmodule

// File: dv/step_sequencer_clock_tb.sv
`timescale 1ns / 100ps

module step_sequencer_clock_tb;

  localparam int CFG_W      = sqc_pkg::CFG_W;
  localparam int LONG_STALL = 300;
  localparam int SETTLE     = 8;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata   = '0;   // step_index, samples_left, zeros
  logic [1:0]       s_tuser   = sqc_pkg::CMD_TICK;   // command
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [7:0]       m_tdata;   // current_step
  logic [1:0]       m_tuser;   // event_res
  logic             cfg_we    = 1'b0;
  logic             cfg_index = sqc_pkg::REG_STEP_LENGTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int errors;
  int pending;
  int tx_idle   = 0;
  int rx_idle   = 0;
  int stall_seq = 0;

  always #5 clk = ~clk;

  step_sequencer_clock dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  step_sequencer_clock_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    int stall_ack;
    stall_ack = 0;
    forever begin
      @(posedge clk);
      if (stall_seq != stall_ack) begin
        stall_ack = stall_seq;
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  initial begin
    #2000000;
    $display("step_sequencer_clock regression: fail");
    $finish;
  end

  task automatic send_item(input sqc_pkg::cmd_t cmd, input logic [7:0] idx,
                           input logic [17:0] left);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, left, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input sqc_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ticks with some step changes, starts and stops; unused fields carry noise.
  task automatic send_random_item();
    int          pick;
    logic [31:0] r;
    logic [17:0] left;
    pick = $urandom_range(0, 99);
    r    = $urandom;
    if (pick < 76) begin
      send_item(sqc_pkg::CMD_TICK, r[7:0], r[25:8]);
    end else if (pick < 88) begin
      left = ($urandom_range(0, 9) == 0) ? r[25:8] : 18'($urandom_range(0, 40));
      send_item(sqc_pkg::CMD_SET_STEP, r[7:0], left);
    end else if (pick < 96) begin
      send_item(sqc_pkg::CMD_START, r[7:0], r[25:8]);
    end else begin
      send_item(sqc_pkg::CMD_STOP, r[7:0], r[25:8]);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] nref;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: a step length of 1.0, note-off disabled.
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_STOP, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_START, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_SET_STEP, 8'd255, 18'h3FFFF);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_SET_STEP, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_SET_STEP, 8'hAA, 18'h15555);
    send_item(sqc_pkg::CMD_SET_STEP, 8'h55, 18'h2AAAA);
    send_item(sqc_pkg::CMD_SET_STEP, 8'h0F, 18'd2);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);
    send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);

    // Longest step length saturates the reload; widest note-off window.
    drain();
    write_reg(sqc_pkg::REG_STEP_LENGTH, {CFG_W{1'b1}});
    write_reg(sqc_pkg::REG_NOTE_REF, CFG_W'(18'h3FFFF));
    send_item(sqc_pkg::CMD_SET_STEP, 8'd3, 18'd2);
    repeat (4) send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);

    // Just under one and a half samples, so the drift pulls steps longer.
    drain();
    write_reg(sqc_pkg::REG_STEP_LENGTH, CFG_W'(98303));
    write_reg(sqc_pkg::REG_NOTE_REF, CFG_W'(25));
    repeat (5) send_item(sqc_pkg::CMD_TICK, 8'd0, 18'd0);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: begin len = CFG_W'(3 * 65536 + 32768); nref = CFG_W'(20); end
        1: begin len = CFG_W'(65536);             nref = CFG_W'(5); end
        2: begin len = CFG_W'(7 * 65536 + 12345); nref = CFG_W'(18'h3FFFF); end
        4: begin len = CFG_W'(2 * 65536 + 32767); nref = CFG_W'(0); end
        6: begin len = {CFG_W{1'b1}};             nref = CFG_W'($urandom_range(0, 400)); end
        default: begin
          len  = CFG_W'(65536 * $urandom_range(1, 30) + $urandom_range(0, 65535));
          nref = CFG_W'($urandom_range(0, 400));
        end
      endcase
      write_reg(sqc_pkg::REG_STEP_LENGTH, len);
      write_reg(sqc_pkg::REG_NOTE_REF, nref);
      if (phase < 3) begin
        tx_idle <= 24;
        rx_idle <= 65;
      end else if (phase < 6) begin
        tx_idle <= 65;
        rx_idle <= 24;
      end else begin
        tx_idle <= 0;
        rx_idle <= 0;
      end
      for (int n = 0; n < 210; n++) begin
        if (n == 100 && (phase == 1 || phase == 6))
          stall_seq <= stall_seq + 1;
        if (n == 100 && phase == 4)
          drain();
        send_random_item();
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("step_sequencer_clock regression: pass");
    end else begin
      $display("step_sequencer_clock regression: fail");
    end
    $finish;
  end

endmodule

// File: step_sequencer_clock.f
hdl/sqc_pkg.sv
hdl/sqc_in_stage.sv
hdl/sqc_core.sv
hdl/step_sequencer_clock.sv
dv/step_sequencer_clock_checker.sv
dv/step_sequencer_clock_tb.sv
